// ===== sv/crcu_pkg.sv =====
// Shared types and constants for the CRC codeword checker and unpacker.
// Used by every module of the block; depends on nothing else.
package crcu_pkg;

   localparam int unsigned CSR_INDEX_WIDTH = 2;
   localparam int unsigned CSR_DATA_WIDTH  = 17;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_GENERATOR_BITS   = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_GENERATOR_LENGTH = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DATAWORD_MODE    = 2'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PAD_BITS         = 2'd3;

   localparam logic [16:0] GENERATOR_BITS_RESET   = 17'd11;
   localparam logic [4:0]  GENERATOR_LENGTH_RESET = 5'd4;
   localparam logic [4:0]  MIN_GENERATOR_LENGTH   = 5'd2;

   localparam logic MODE_NIBBLE = 1'b0;
   localparam logic MODE_BYTE   = 1'b1;

   localparam int unsigned NIBBLE_BITS  = 4;
   localparam int unsigned BYTE_BITS    = 8;
   localparam int unsigned RESULT_WIDTH = 32;
   localparam int unsigned QUEUE_DEPTH  = 2;

   typedef struct packed {
      logic [16:0] generator_bits;
      logic [4:0]  generator_length;
      logic        dataword_mode;
      logic [2:0]  pad_bits;
   } cfg_type;

   // Generator length limited to the range the datapath supports.
   function automatic logic [4:0] clamp_gen_len(input logic [4:0] len,
                                                input int unsigned max_bits);
      logic [4:0] res;
      if (len < MIN_GENERATOR_LENGTH) begin
         res = MIN_GENERATOR_LENGTH;
      end else if (32'(len) > max_bits) begin
         res = 5'(max_bits);
      end else begin
         res = len;
      end
      return res;
   endfunction

endpackage

// ===== sv/crcu_front.sv =====
// Front end: collects stream bytes into the group buffer and detects the end of a group.
// A completed group is pushed into the queue. Depends on crcu_pkg.
module crcu_front #(
   parameter int unsigned MAX_GENERATOR_BITS = 17,
   parameter int unsigned BUF_BYTES          = 6
) (
   input  logic                     clock,
   input  logic                     reset,
   input  crcu_pkg::cfg_type        cfg,
   input  logic                     req_valid,
   input  logic [7:0]               req_stream_byte,
   output logic                     req_stall,
   input  logic                     q_full,
   output logic                     q_push,
   output logic [8*BUF_BYTES-1:0]   q_data
);

   localparam int unsigned IDXW = (BUF_BYTES > 1) ? $clog2(BUF_BYTES) : 1;

   logic [7:0]      buf_ff [BUF_BYTES];
   logic [7:0]      buf_in [BUF_BYTES];
   logic [IDXW-1:0] index_ff;
   logic [IDXW-1:0] index_in;

   logic [4:0]  glen;
   logic [5:0]  cw_len;
   logic [7:0]  total;
   logic [5:0]  group_bytes;
   logic [IDXW:0] count_next;
   logic        accept;
   logic        complete;

   assign glen   = crcu_pkg::clamp_gen_len(cfg.generator_length, MAX_GENERATOR_BITS);
   assign cw_len = ((cfg.dataword_mode == crcu_pkg::MODE_BYTE) ?
                    6'(crcu_pkg::BYTE_BITS) : 6'(crcu_pkg::NIBBLE_BITS))
                   + 6'(glen) - 6'd1;
   assign total  = 8'(cfg.pad_bits) + ((cfg.dataword_mode == crcu_pkg::MODE_BYTE) ?
                   8'(cw_len) : (8'(cw_len) << 1));
   assign group_bytes = 6'((9'(total) + 9'd7) >> 3);

   assign count_next = {1'b0, index_ff} + (IDXW+1)'(1);
   assign complete   = 6'(count_next) >= group_bytes;
   assign req_stall  = q_full;
   assign accept     = req_valid && !q_full;
   assign q_push     = accept && complete;

   // The pushed group includes the byte arriving in this cycle.
   always_comb begin
      for (int j = 0; j < BUF_BYTES; j++) begin
         if (IDXW'(j) == index_ff) begin
            q_data[8*(BUF_BYTES-j)-1 -: 8] = req_stream_byte;
         end else begin
            q_data[8*(BUF_BYTES-j)-1 -: 8] = buf_ff[j];
         end
      end
   end

   always_comb begin
      index_in = index_ff;
      for (int j = 0; j < BUF_BYTES; j++) begin
         buf_in[j] = buf_ff[j];
      end
      if (accept) begin
         for (int j = 0; j < BUF_BYTES; j++) begin
            if (IDXW'(j) == index_ff) begin
               buf_in[j] = req_stream_byte;
            end
         end
         index_in = complete ? '0 : count_next[IDXW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         index_ff <= '0;
         for (int j = 0; j < BUF_BYTES; j++) begin
            buf_ff[j] <= '0;
         end
      end else begin
         index_ff <= index_in;
         for (int j = 0; j < BUF_BYTES; j++) begin
            buf_ff[j] <= buf_in[j];
         end
      end
   end

`ifndef SYNTHESIS
   a_index_in_range: assert property (@(posedge clock) disable iff (reset)
      32'(index_ff) < BUF_BYTES)
      else $error("group byte index ran past the buffer");
`endif

endmodule

// ===== sv/crcu_queue.sv =====
// Short queue of completed groups between the front end and the checking pipeline.
// Depends on crcu_pkg for its depth.
module crcu_queue #(
   parameter int unsigned WIDTH = 48
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic             valid,
   output logic [WIDTH-1:0] pop_data
);

   localparam int unsigned PW = $clog2(crcu_pkg::QUEUE_DEPTH);
   localparam int unsigned CW = $clog2(crcu_pkg::QUEUE_DEPTH + 1);

   logic [WIDTH-1:0] entry_ff [crcu_pkg::QUEUE_DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_pop;

   assign full     = count_ff == CW'(crcu_pkg::QUEUE_DEPTH);
   assign valid    = count_ff != '0;
   assign pop_data = entry_ff[rd_ptr_ff];
   assign do_pop   = pop && valid;

   always_comb begin
      wr_ptr_in = push   ? wr_ptr_ff + PW'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + PW'(1) : rd_ptr_ff;
      count_in  = count_ff + CW'(push) - CW'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

`ifndef SYNTHESIS
   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("group pushed into a full queue");
`endif

endmodule

// ===== sv/crcu_back.sv =====
// Back end: extracts the codewords of a group, divides them in 8-bit CRC stages,
// updates the saturating totals and holds the result register. Depends on crcu_pkg.
module crcu_back #(
   parameter int unsigned MAX_GENERATOR_BITS = 17,
   parameter int unsigned COUNT_WIDTH        = 32,
   parameter int unsigned BUF_BYTES          = 6
) (
   input  logic                              clock,
   input  logic                              reset,
   input  crcu_pkg::cfg_type                 cfg,
   input  logic                              q_valid,
   input  logic [8*BUF_BYTES-1:0]            q_data,
   output logic                              q_pop,
   input  logic                              rsp_stall,
   output logic                              rsp_valid,
   output logic [7:0]                        rsp_decoded_byte,
   output logic [1:0]                        rsp_group_error_flags,
   output logic [crcu_pkg::RESULT_WIDTH-1:0] rsp_codewords_checked,
   output logic [crcu_pkg::RESULT_WIDTH-1:0] rsp_codewords_failed
);

   localparam int unsigned M    = MAX_GENERATOR_BITS;
   localparam int unsigned BUFW = 8 * BUF_BYTES;
   localparam int unsigned CWW  = crcu_pkg::BYTE_BITS + M - 1;
   localparam int unsigned NST  = (CWW + 7) / 8;
   localparam int unsigned CWP  = 8 * NST;
   localparam int unsigned SW   = $clog2(BUFW + 1);
   localparam int unsigned RW   = crcu_pkg::RESULT_WIDTH;

   // Eight division steps; the remainder never reaches the top bit after a step.
   function automatic logic [M-1:0] crc_chunk(input logic [M-1:0] rem_start,
                                              input logic [7:0]   bits,
                                              input logic [M-1:0] top_bit,
                                              input logic [M-1:0] div);
      logic [M-1:0] r;
      int           i;
      r = rem_start;
      for (i = 0; i < 8; i++) begin
         r = {r[M-2:0], bits[7-i]};
         if ((r & top_bit) != '0) begin
            r = r ^ div;
         end
      end
      return r;
   endfunction

   logic           vld_ff  [NST+1];
   logic [CWP-1:0] cw1_ff  [NST+1];
   logic [CWP-1:0] cw2_ff  [NST+1];
   logic [M-1:0]   rem1_ff [NST+1];
   logic [M-1:0]   rem2_ff [NST+1];
   logic [7:0]     data_ff [NST+1];
   logic [M-1:0]   rem1_in [NST+1];
   logic [M-1:0]   rem2_in [NST+1];

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [7:0]             decoded_ff;
   logic [1:0]             flags_ff;
   logic [COUNT_WIDTH-1:0] checked_ff, checked_in;
   logic [COUNT_WIDTH-1:0] failed_ff, failed_in;

   logic              adv;
   logic              nibble_mode;
   logic [4:0]        glen;
   logic [M-1:0]      top;
   logic [M+16:0]     gen_ext;
   logic [M-1:0]      divisor;
   logic [5:0]        cw_len;
   logic [SW-1:0]     shift1, shift2;
   logic [CWP-1:0]    mask;
   logic [BUFW+CWP-1:0] ext1, ext2;
   logic [CWP-1:0]    cw1, cw2, d1, d2;
   logic [7:0]        data_byte;
   logic              fail1, fail2;
   logic [COUNT_WIDTH:0] checked_sum, failed_sum;
   logic [COUNT_WIDTH+RW-1:0] checked_ext, failed_ext;

   // The whole pipeline moves unless a finished result is held by the receiver.
   assign adv         = !(rsp_valid_ff && rsp_stall);
   assign q_pop       = q_valid && adv;
   assign nibble_mode = cfg.dataword_mode == crcu_pkg::MODE_NIBBLE;

   assign glen    = crcu_pkg::clamp_gen_len(cfg.generator_length, M);
   assign top     = M'(1) << (glen - 5'd1);
   assign gen_ext = {{M{1'b0}}, cfg.generator_bits};
   assign divisor = (gen_ext[M-1:0] & (top - M'(1))) | top;

   // Codeword extraction: the group is MSB first, so a codeword starting at bit
   // position p with length L sits L+p bits below the top of the buffer.
   assign cw_len = (nibble_mode ? 6'(crcu_pkg::NIBBLE_BITS) : 6'(crcu_pkg::BYTE_BITS))
                   + 6'(glen) - 6'd1;
   assign shift1 = SW'(BUFW) - SW'(cfg.pad_bits) - SW'(cw_len);
   assign shift2 = shift1 - SW'(cw_len);
   assign mask   = ~({CWP{1'b1}} << cw_len);
   assign ext1   = {{CWP{1'b0}}, q_data} >> shift1;
   assign ext2   = {{CWP{1'b0}}, q_data} >> shift2;
   assign cw1    = ext1[CWP-1:0] & mask;
   assign cw2    = ext2[CWP-1:0] & mask;
   assign d1     = cw1 >> (glen - 5'd1);
   assign d2     = cw2 >> (glen - 5'd1);
   assign data_byte = nibble_mode ? {d1[3:0], d2[3:0]} : d1[7:0];

   assign rem1_in[0] = '0;
   assign rem2_in[0] = '0;

   for (genvar s = 1; s <= NST; s++) begin : g_crc
      assign rem1_in[s] = crc_chunk(rem1_ff[s-1], cw1_ff[s-1][CWP-1-8*(s-1) -: 8],
                                    top, divisor);
      assign rem2_in[s] = crc_chunk(rem2_ff[s-1], cw2_ff[s-1][CWP-1-8*(s-1) -: 8],
                                    top, divisor);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s <= NST; s++) begin
            vld_ff[s] <= 1'b0;
         end
      end else if (adv) begin
         vld_ff[0] <= q_pop;
         for (int s = 1; s <= NST; s++) begin
            vld_ff[s] <= vld_ff[s-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         cw1_ff[0]  <= cw1;
         cw2_ff[0]  <= cw2;
         data_ff[0] <= data_byte;
         for (int s = 0; s <= NST; s++) begin
            rem1_ff[s] <= rem1_in[s];
            rem2_ff[s] <= rem2_in[s];
         end
         for (int s = 1; s <= NST; s++) begin
            cw1_ff[s]  <= cw1_ff[s-1];
            cw2_ff[s]  <= cw2_ff[s-1];
            data_ff[s] <= data_ff[s-1];
         end
      end
   end

   assign fail1 = rem1_ff[NST] != '0;
   assign fail2 = nibble_mode && (rem2_ff[NST] != '0);

   always_comb begin
      checked_sum = {1'b0, checked_ff}
                    + (nibble_mode ? (COUNT_WIDTH+1)'(2) : (COUNT_WIDTH+1)'(1));
      failed_sum  = {1'b0, failed_ff} + (COUNT_WIDTH+1)'(fail1) + (COUNT_WIDTH+1)'(fail2);
      checked_in  = checked_sum[COUNT_WIDTH] ? '1 : checked_sum[COUNT_WIDTH-1:0];
      failed_in   = failed_sum[COUNT_WIDTH]  ? '1 : failed_sum[COUNT_WIDTH-1:0];
      rsp_valid_in = adv ? vld_ff[NST] : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         checked_ff   <= '0;
         failed_ff    <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (adv && vld_ff[NST]) begin
            checked_ff <= checked_in;
            failed_ff  <= failed_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv && vld_ff[NST]) begin
         decoded_ff <= data_ff[NST];
         flags_ff   <= {fail1, fail2};
      end
   end

   // The totals only change as a result enters the output register, so they
   // are shown directly with the transaction.
   assign checked_ext = {{RW{1'b0}}, checked_ff};
   assign failed_ext  = {{RW{1'b0}}, failed_ff};

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_decoded_byte      = decoded_ff;
   assign rsp_group_error_flags = flags_ff;
   assign rsp_codewords_checked = checked_ext[RW-1:0];
   assign rsp_codewords_failed  = failed_ext[RW-1:0];

`ifndef SYNTHESIS
   a_failed_le_checked: assert property (@(posedge clock) disable iff (reset)
      failed_ff <= checked_ff)
      else $error("failed total exceeds checked total");

   a_totals_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |=> ($stable(checked_ff) && $stable(failed_ff)))
      else $error("totals changed under a stalled transaction");

   a_byte_mode_flag: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !nibble_mode) |-> (flags_ff[0] == 1'b0))
      else $error("second codeword flag set in byte mode");
`endif

endmodule

// ===== sv/crc_codeword_checker_unpacker.sv =====
// CRC codeword checker and unpacker. Takes one stream byte per cycle, MSB first,
// groups the bytes by pad bits and codeword sizes, and for each finished group
// returns the recovered data byte, per-codeword error flags and saturating totals.
// The front end accepts a byte every cycle while the two-entry group queue has
// room; the checking pipeline divides each codeword in ceil((MAX_GENERATOR_BITS+7)/8)
// stages of eight CRC steps; the sustained rate is one byte per cycle unless the
// receiver stalls a result. Configuration registers are written through the csr
// port while the block is idle, a rule for the user that the block does not enforce.
module crc_codeword_checker_unpacker #(
   parameter int unsigned MAX_GENERATOR_BITS = 17,
   parameter int unsigned COUNT_WIDTH        = 32
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write_enable,
   input  logic [crcu_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [crcu_pkg::CSR_DATA_WIDTH-1:0]  csr_write_data,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [7:0]                           req_stream_byte,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [7:0]                           rsp_decoded_byte,
   output logic [1:0]                           rsp_group_error_flags,
   output logic [crcu_pkg::RESULT_WIDTH-1:0]    rsp_codewords_checked,
   output logic [crcu_pkg::RESULT_WIDTH-1:0]    rsp_codewords_failed
);

   localparam int unsigned BUF_BYTES = (2 * (4 + MAX_GENERATOR_BITS - 1) + 14) / 8;
   localparam int unsigned BUFW      = 8 * BUF_BYTES;

   crcu_pkg::cfg_type cfg_ff, cfg_in;

   logic            q_push, q_full, q_pop, q_valid;
   logic [BUFW-1:0] q_push_data, q_pop_data;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            crcu_pkg::CSR_GENERATOR_BITS:   cfg_in.generator_bits   = csr_write_data;
            crcu_pkg::CSR_GENERATOR_LENGTH: cfg_in.generator_length = csr_write_data[4:0];
            crcu_pkg::CSR_DATAWORD_MODE:    cfg_in.dataword_mode    = csr_write_data[0];
            crcu_pkg::CSR_PAD_BITS:         cfg_in.pad_bits         = csr_write_data[2:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.generator_bits   <= crcu_pkg::GENERATOR_BITS_RESET;
         cfg_ff.generator_length <= crcu_pkg::GENERATOR_LENGTH_RESET;
         cfg_ff.dataword_mode    <= crcu_pkg::MODE_NIBBLE;
         cfg_ff.pad_bits         <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   crcu_front #(
      .MAX_GENERATOR_BITS(MAX_GENERATOR_BITS),
      .BUF_BYTES(BUF_BYTES)
   ) u_front (
      .clock(clock),
      .reset(reset),
      .cfg(cfg_ff),
      .req_valid(req_valid),
      .req_stream_byte(req_stream_byte),
      .req_stall(req_stall),
      .q_full(q_full),
      .q_push(q_push),
      .q_data(q_push_data)
   );

   crcu_queue #(
      .WIDTH(BUFW)
   ) u_queue (
      .clock(clock),
      .reset(reset),
      .push(q_push),
      .push_data(q_push_data),
      .full(q_full),
      .pop(q_pop),
      .valid(q_valid),
      .pop_data(q_pop_data)
   );

   crcu_back #(
      .MAX_GENERATOR_BITS(MAX_GENERATOR_BITS),
      .COUNT_WIDTH(COUNT_WIDTH),
      .BUF_BYTES(BUF_BYTES)
   ) u_back (
      .clock(clock),
      .reset(reset),
      .cfg(cfg_ff),
      .q_valid(q_valid),
      .q_data(q_pop_data),
      .q_pop(q_pop),
      .rsp_stall(rsp_stall),
      .rsp_valid(rsp_valid),
      .rsp_decoded_byte(rsp_decoded_byte),
      .rsp_group_error_flags(rsp_group_error_flags),
      .rsp_codewords_checked(rsp_codewords_checked),
      .rsp_codewords_failed(rsp_codewords_failed)
   );

endmodule
